@@ rtl/dcmc_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and types of the DNA core match classifier.
// Used by the channel interfaces and the top level; depends on nothing.
package dcmc_pkg;

  localparam int NODE_W    = 12;
  localparam int NODES     = 1 << NODE_W;
  localparam int SYM_W     = 2;
  localparam int TRANS_AW  = NODE_W + SYM_W;
  localparam int TRANS_N   = 1 << TRANS_AW;
  localparam int OP_W      = 2;
  localparam int DEPTH_W   = 6;
  localparam int MAX_DEPTH = 32;
  localparam int COUNT_W   = 32;
  localparam int MAX_READ  = 1024;
  localparam int POS_W     = $clog2(MAX_READ);
  localparam int BPOS_W    = POS_W + 1;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_COUNT_ON_BUCKET = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_BASE  = 2'd0,
    OP_TRANS = 2'd1,
    OP_ATTR  = 2'd2
  } op_t;

  // one word of the node memory
  typedef struct packed {
    logic               link_v;
    logic [NODE_W-1:0]  link_node;
    logic [DEPTH_W-1:0] depth;
    logic [COUNT_W-1:0] count;
  } node_word_t;

  // item held in the first two pipeline stages
  typedef struct packed {
    logic               base;
    logic               attr;
    logic               last;
    logic [NODE_W-1:0]  node;
    logic [NODE_W-1:0]  target;
    logic               has_link;
    logic [DEPTH_W-1:0] depth;
    logic [COUNT_W-1:0] count;
    logic [POS_W-1:0]   pos;
  } stage_t;

  // item held in the compare stage
  typedef struct packed {
    logic              base;
    logic              last;
    logic              hit;
    logic [NODE_W-1:0] xnode;
    logic [POS_W-1:0]  pos;
  } cmp_t;

endpackage

@@ rtl/dcmc_in_if.sv @@
`timescale 1ns / 1ps
// Input channel of the classifier: valid/ready plus one load or base item.
// Depends on dcmc_pkg for field widths.
interface dcmc_in_if;
  import dcmc_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [SYM_W-1:0]   symbol;
  logic               last_symbol;
  logic [NODE_W-1:0]  node;
  logic [NODE_W-1:0]  target_node;
  logic               has_output_link;
  logic [DEPTH_W-1:0] depth;
  logic [COUNT_W-1:0] match_count;

  modport source (
    output valid, operation, symbol, last_symbol, node, target_node,
           has_output_link, depth, match_count,
    input  ready
  );
  modport sink (
    input  valid, operation, symbol, last_symbol, node, target_node,
           has_output_link, depth, match_count,
    output ready
  );
endinterface

@@ rtl/dcmc_out_if.sv @@
`timescale 1ns / 1ps
// Result channel of the classifier: valid/ready plus one per-read result.
// Depends on dcmc_pkg for field widths.
interface dcmc_out_if;
  import dcmc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [NODE_W-1:0]        bucket_node;
  logic signed [BPOS_W-1:0] best_pos;
  logic                     found;

  modport source (output valid, bucket_node, best_pos, found, input ready);
  modport sink   (input valid, bucket_node, best_pos, found, output ready);
endinterface

@@ rtl/dna_core_match_classifier.sv @@
`timescale 1ns / 1ps
// A result is registered as the final base of a read leaves the compare stage.
// Throughput: one item per cycle when not stalled or held; the transition memory read
// closes the per-base loop. With count_on_bucket set, input is held after a final base
// until the node memory has done the count read-modify-write. Sync active-low reset clears
// the read state and pipeline; memory contents are undefined until loaded (no clear pass).
module dna_core_match_classifier (
  input  logic                           clk,
  input  logic                           rst_n,
  dcmc_in_if.sink                        in_ch,
  dcmc_out_if.source                     out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [dcmc_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [dcmc_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [dcmc_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready
);
  import dcmc_pkg::*;

  localparam logic [POS_W-1:0]   POS_MAX   = POS_W'(MAX_READ - 1);
  localparam logic [DEPTH_W-1:0] DEPTH_SAT = DEPTH_W'(MAX_DEPTH);

  // memories
  logic [NODE_W-1:0] trans_mem [TRANS_N];
  node_word_t        node_mem  [NODES];

  logic              cob_r;
  logic              adv;
  logic              accept;
  logic              in_base;
  logic              in_trans;
  logic              in_attr;

  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [NODE_W-1:0] trans_q_r;

  logic              s1_v_r, s2_v_r, s3_v_r;
  stage_t            s1_r, s2_r, s1_nxt;
  cmp_t              s3_r, s3_nxt;

  node_word_t        rd1_r, rd2_r;
  logic              fwd_r;
  logic              fwd_link_v_r;
  logic [NODE_W-1:0] fwd_link_node_r;
  logic              link_v;
  logic [NODE_W-1:0] link_node;
  node_word_t        s2_word;

  logic              rd1_en;
  logic              rd2_en;
  logic [NODE_W-1:0] rd2_addr;
  logic              node_we;
  logic [NODE_W-1:0] node_waddr;
  node_word_t        node_wdata;
  node_word_t        inc_word;

  logic              s3_res;
  logic              inc_rd;
  logic              inc_r;
  logic [NODE_W-1:0] inc_node_r;
  logic              hold_r, hold_nxt;

  logic              best_v_r, best_v_nxt;
  logic [NODE_W-1:0] best_node_r, best_node_nxt;
  logic [DEPTH_W-1:0] best_depth_r, best_depth_nxt;
  logic [COUNT_W-1:0] best_count_r, best_count_nxt;
  logic [POS_W-1:0]  best_idx_r, best_idx_nxt;
  logic              take;
  logic [NODE_W-1:0] res_node;

  logic                     out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]        out_node_r;
  logic signed [BPOS_W-1:0] out_pos_r;
  logic                     out_found_r;

  logic cfg_wr;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cob_r <= 1'b0;
    end else if (cfg_wr && cfg_paddr[CFG_AW-1:2] == REG_COUNT_ON_BUCKET) begin
      cob_r <= cfg_pwdata[0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_AW-1:2] == REG_COUNT_ON_BUCKET) begin
      cfg_prdata[0] = cob_r;
    end
  end

  // stall only when a result must enter a full output register
  assign s3_res      = s3_v_r && s3_r.base && s3_r.last;
  assign adv         = !(s3_res && out_valid_r && !out_ch.ready);
  assign in_ch.ready = adv && !hold_r;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    in_base  = 1'b0;
    in_trans = 1'b0;
    in_attr  = 1'b0;
    unique case (in_ch.operation)
      OP_BASE:  in_base  = 1'b1;
      OP_TRANS: in_trans = 1'b1;
      OP_ATTR:  in_attr  = 1'b1;
      default:  ;
    endcase
  end

  // stage 0: current node comes from the previous base's transition read
  always_comb begin
    cur_nxt = cur_r;
    if (s1_v_r && s1_r.base) begin
      cur_nxt = s1_r.last ? '0 : trans_q_r;
    end
    pos_nxt = pos_r;
    if (accept && in_base) begin
      pos_nxt = in_ch.last_symbol ? '0 : ((pos_r == POS_MAX) ? pos_r : pos_r + 1'b1);
    end
    s1_nxt.base     = in_base;
    s1_nxt.attr     = in_attr;
    s1_nxt.last     = in_ch.last_symbol;
    s1_nxt.node     = in_ch.node;
    s1_nxt.target   = in_ch.target_node;
    s1_nxt.has_link = in_ch.has_output_link;
    s1_nxt.depth    = (in_ch.depth > DEPTH_SAT) ? DEPTH_SAT : in_ch.depth;
    s1_nxt.count    = in_ch.match_count;
    s1_nxt.pos      = pos_r;
  end

  always_ff @(posedge clk) begin
    if (accept && in_trans) begin
      trans_mem[{in_ch.node, in_ch.symbol}] <= in_ch.target_node;
    end
    if (accept && in_base) begin
      trans_q_r <= trans_mem[{cur_nxt, in_ch.symbol}];
    end
  end

  // stage 1: read the output link of the new node
  assign s2_word.link_v    = s2_r.has_link;
  assign s2_word.link_node = s2_r.target;
  assign s2_word.depth     = s2_r.depth;
  assign s2_word.count     = s2_r.count;
  assign rd1_en = adv && s1_v_r && s1_r.base;

  always_ff @(posedge clk) begin
    if (rd1_en) begin
      rd1_r           <= node_mem[trans_q_r];
      // attribute write in stage 2 at the same edge: bypass it
      fwd_r           <= s2_v_r && s2_r.attr && s2_r.node == trans_q_r;
      fwd_link_v_r    <= s2_r.has_link;
      fwd_link_node_r <= s2_r.target;
    end
  end

  // stage 2: read depth and count of the linked node, or write attributes
  assign link_v    = fwd_r ? fwd_link_v_r    : rd1_r.link_v;
  assign link_node = fwd_r ? fwd_link_node_r : rd1_r.link_node;

  always_comb begin
    take = 1'b0;
    if (s3_r.hit) begin
      take = !best_v_r || best_depth_r < rd2_r.depth ||
             (best_depth_r == rd2_r.depth && best_count_r < rd2_r.count);
    end
    best_v_nxt     = best_v_r;
    best_node_nxt  = best_node_r;
    best_depth_nxt = best_depth_r;
    best_count_nxt = best_count_r;
    best_idx_nxt   = best_idx_r;
    if (take) begin
      best_v_nxt     = 1'b1;
      best_node_nxt  = s3_r.xnode;
      best_depth_nxt = rd2_r.depth;
      best_count_nxt = rd2_r.count;
      best_idx_nxt   = s3_r.pos;
    end
    res_node = best_v_nxt ? best_node_nxt : '0;
  end

  assign inc_rd   = adv && s3_res && cob_r;
  assign rd2_en   = (adv && s2_v_r && s2_r.base && link_v) || inc_rd;
  assign rd2_addr = inc_rd ? res_node : link_node;

  always_comb begin
    inc_word       = rd2_r;
    inc_word.count = (rd2_r.count == '1) ? rd2_r.count : rd2_r.count + 1'b1;
  end

  // the count update runs only with the pipeline empty, so one write port serves both
  assign node_we    = inc_r || (adv && s2_v_r && s2_r.attr);
  assign node_waddr = inc_r ? inc_node_r : s2_r.node;
  assign node_wdata = inc_r ? inc_word : s2_word;

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (rd2_en) begin
      rd2_r <= node_mem[rd2_addr];
    end
  end

  always_comb begin
    s3_nxt.base  = s2_r.base;
    s3_nxt.last  = s2_r.last;
    s3_nxt.hit   = s2_r.base && link_v;
    s3_nxt.xnode = link_node;
    s3_nxt.pos   = s2_r.pos;
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s1_r;
      s3_r <= s3_nxt;
    end
    if (adv && s3_res) begin
      out_node_r  <= res_node;
      out_pos_r   <= best_v_nxt ? $signed({1'b0, best_idx_nxt}) : '1;
      out_found_r <= best_v_nxt;
    end
    if (inc_rd) begin
      inc_node_r <= res_node;
    end
  end

  // stage 3: compare and emit
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv && s3_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    hold_nxt = hold_r;
    if (accept && in_base && in_ch.last_symbol && cob_r) begin
      hold_nxt = 1'b1;
    end else if (inc_r) begin
      hold_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      cur_r        <= '0;
      pos_r        <= '0;
      best_v_r     <= 1'b0;
      best_node_r  <= '0;
      best_depth_r <= '0;
      best_count_r <= '0;
      best_idx_r   <= '0;
      out_valid_r  <= 1'b0;
      inc_r        <= 1'b0;
      hold_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      hold_r      <= hold_nxt;
      inc_r       <= inc_rd;
      pos_r       <= pos_nxt;
      if (adv) begin
        s1_v_r <= accept;
        s2_v_r <= s1_v_r;
        s3_v_r <= s2_v_r;
        cur_r  <= cur_nxt;
        if (s3_v_r && s3_r.base) begin
          if (s3_r.last) begin
            best_v_r     <= 1'b0;
            best_node_r  <= '0;
            best_depth_r <= '0;
            best_count_r <= '0;
            best_idx_r   <= '0;
          end else begin
            best_v_r     <= best_v_nxt;
            best_node_r  <= best_node_nxt;
            best_depth_r <= best_depth_nxt;
            best_count_r <= best_count_nxt;
            best_idx_r   <= best_idx_nxt;
          end
        end
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.bucket_node = out_node_r;
  assign out_ch.best_pos    = out_pos_r;
  assign out_ch.found       = out_found_r;

  // count update must find the pipeline drained and input held
  a_inc_empty: assert property (@(posedge clk) disable iff (!rst_n)
    inc_r |-> !s1_v_r && !s2_v_r && !s3_v_r && hold_r)
    else $error("count update overlaps items in flight");

  // a new result only follows a final base leaving the compare stage
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s3_res && adv))
    else $error("result without a final base");

  // no match means root node and position minus one
  a_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_node_r == '0 && out_pos_r == '1)
    else $error("empty result carries a node or position");

  // a count update never coincides with an attribute write or a stage 1 link read
  a_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    inc_r |-> !(s2_v_r && s2_r.attr) && !rd1_en)
    else $error("node memory write conflict");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for dna_core_match_classifier: loads small automata, streams reads
// and compares every per-read bucket result with an in-bench prediction of the matcher.
// Depends on dcmc_pkg and the dcmc_in_if / dcmc_out_if channel interfaces.
module tb_top;
  import dcmc_pkg::*;

  localparam logic [OP_W-1:0]   OP_SPARE = 2'd3;
  localparam logic [SYM_W-1:0]  SYM_A = 2'd0;
  localparam logic [SYM_W-1:0]  SYM_C = 2'd1;
  localparam logic [SYM_W-1:0]  SYM_G = 2'd2;
  localparam logic [SYM_W-1:0]  SYM_T = 2'd3;
  localparam logic [CFG_AW-1:0] BUCKET_ADDR = {REG_COUNT_ON_BUCKET, 2'b00};
  localparam int                TAIL_CYCLES = 12;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [SYM_W-1:0]   sym;
    logic               last;
    logic [NODE_W-1:0]  node;
    logic [NODE_W-1:0]  target;
    logic               has_link;
    logic [DEPTH_W-1:0] depth;
    logic [COUNT_W-1:0] count;
  } dna_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [BPOS_W-1:0] pos;
    logic              found;
  } bucket_t;

  logic clk;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  dcmc_in_if  in_ch ();
  dcmc_out_if out_ch ();

  dna_core_match_classifier DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predicted matcher state
  logic [NODE_W-1:0]  next_node  [TRANS_N];
  logic               link_valid [NODES];
  logic [NODE_W-1:0]  link_node  [NODES];
  logic [DEPTH_W-1:0] node_depth [NODES];
  logic [COUNT_W-1:0] node_count [NODES];
  logic [NODE_W-1:0]  walk_node;
  logic [NODE_W-1:0]  lead_node;
  logic [DEPTH_W-1:0] lead_depth;
  logic [COUNT_W-1:0] lead_count;
  logic               lead_valid;
  logic [BPOS_W-1:0]  lead_pos;
  logic [POS_W-1:0]   base_pos;
  logic               bucket_on;

  bucket_t bucket_q[$];

  // nodes whose whole fan-out is loaded and leads only to such nodes
  bit          is_member [NODES];
  int unsigned members[$];

  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned gap_pct;
  int unsigned stall_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(4_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void clear_read();
    walk_node  = '0;
    lead_node  = '0;
    lead_depth = '0;
    lead_count = '0;
    lead_valid = 1'b0;
    lead_pos   = '1;
    base_pos   = '0;
  endfunction

  function automatic void classify(dna_item_t it);
    logic [NODE_W-1:0]  hit;
    logic [DEPTH_W-1:0] hit_depth;
    logic [COUNT_W-1:0] hit_count;
    bucket_t            res;
    case (it.op)
      OP_TRANS: next_node[{it.node, it.sym}] = it.target;
      OP_ATTR: begin
        link_valid[it.node] = it.has_link;
        link_node[it.node]  = it.target;
        node_depth[it.node] = (it.depth > MAX_DEPTH) ? DEPTH_W'(MAX_DEPTH) : it.depth;
        node_count[it.node] = it.count;
      end
      OP_BASE: begin
        walk_node = next_node[{walk_node, it.sym}];
        if (link_valid[walk_node]) begin
          hit       = link_node[walk_node];
          hit_depth = node_depth[hit];
          hit_count = node_count[hit];
          if (!lead_valid || lead_depth < hit_depth ||
              (lead_depth == hit_depth && lead_count < hit_count)) begin
            lead_valid = 1'b1;
            lead_node  = hit;
            lead_depth = hit_depth;
            lead_count = hit_count;
            lead_pos   = BPOS_W'(base_pos);
          end
        end
        if (base_pos != POS_W'(MAX_READ - 1)) base_pos++;
        if (it.last) begin
          res.node  = lead_valid ? lead_node : '0;
          res.pos   = lead_valid ? lead_pos : '1;
          res.found = lead_valid;
          bucket_q.push_back(res);
          if (bucket_on && node_count[res.node] != '1) node_count[res.node]++;
          clear_read();
        end
      end
      default: ;
    endcase
  endfunction

  task automatic flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // result checker
  always @(posedge clk) begin
    bucket_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (bucket_q.size() == 0) begin
        flag($sformatf("result with none pending: node %0d pos %0d found %0b",
                       out_ch.bucket_node, $signed(out_ch.best_pos), out_ch.found));
      end else begin
        want = bucket_q.pop_front();
        if (out_ch.bucket_node !== want.node)
          flag($sformatf("bucket_node: expected %0d, got %0d", want.node, out_ch.bucket_node));
        if (out_ch.best_pos !== want.pos)
          flag($sformatf("best_pos: expected %0d, got %0d",
                         $signed(want.pos), $signed(out_ch.best_pos)));
        if (out_ch.found !== want.found)
          flag($sformatf("found: expected %0b, got %0b", want.found, out_ch.found));
      end
    end
  end

  // result-side backpressure in bursts
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        hold_left = $urandom_range(1, 13);
      out_ch.ready <= (hold_left == 0);
      if (hold_left != 0) hold_left--;
    end
  end

  function automatic dna_item_t rand_fields();
    dna_item_t it;
    it.op       = OP_W'($urandom);
    it.sym      = SYM_W'($urandom);
    it.last     = 1'($urandom);
    it.node     = NODE_W'($urandom);
    it.target   = NODE_W'($urandom);
    it.has_link = 1'($urandom);
    it.depth    = DEPTH_W'($urandom);
    it.count    = $urandom;
    return it;
  endfunction

  function automatic logic [COUNT_W-1:0] rand_count();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [NODE_W-1:0] pick_member();
    return NODE_W'(members[$urandom_range(0, members.size() - 1)]);
  endfunction

  function automatic logic [NODE_W-1:0] pick_outsider();
    logic [NODE_W-1:0] n;
    do n = NODE_W'($urandom); while (is_member[n]);
    return n;
  endfunction

  task automatic send_item(dna_item_t it);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.operation       <= it.op;
    in_ch.symbol          <= it.sym;
    in_ch.last_symbol     <= it.last;
    in_ch.node            <= it.node;
    in_ch.target_node     <= it.target;
    in_ch.has_output_link <= it.has_link;
    in_ch.depth           <= it.depth;
    in_ch.match_count     <= it.count;
    do @(posedge clk); while (!in_ch.ready);
    classify(it);
    if (it.op != OP_SPARE) items_sent++;
  endtask

  task automatic send_base(logic [SYM_W-1:0] sym, logic last);
    dna_item_t it;
    it      = rand_fields();
    it.op   = OP_BASE;
    it.sym  = sym;
    it.last = last;
    send_item(it);
  endtask

  task automatic load_edge(logic [NODE_W-1:0] n, logic [SYM_W-1:0] sym,
                           logic [NODE_W-1:0] tgt);
    dna_item_t it;
    it        = rand_fields();
    it.op     = OP_TRANS;
    it.node   = n;
    it.sym    = sym;
    it.target = tgt;
    send_item(it);
  endtask

  task automatic load_attr(logic [NODE_W-1:0] n, logic has_link, logic [NODE_W-1:0] tgt,
                           logic [DEPTH_W-1:0] d, logic [COUNT_W-1:0] c);
    dna_item_t it;
    it          = rand_fields();
    it.op       = OP_ATTR;
    it.node     = n;
    it.has_link = has_link;
    it.target   = tgt;
    it.depth    = d;
    it.count    = c;
    send_item(it);
  endtask

  task automatic read_seq(string s);
    logic [SYM_W-1:0] code;
    for (int i = 0; i < s.len(); i++) begin
      case (s[i])
        "A": code = SYM_A;
        "C": code = SYM_C;
        "G": code = SYM_G;
        default: code = SYM_T;
      endcase
      send_base(code, i == s.len() - 1);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (bucket_q.size() != 0) @(posedge clk);
    // let trailing loads and the count update settle
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_bucketing(logic on);
    wait_drained();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= BUCKET_ADDR;
    cfg_pwdata  <= CFG_DW'(on);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    bucket_on = on;
    // go straight into a read-back setup phase
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DW'(on))
      flag($sformatf("count_on_bucket read: expected %0d, got %0d", on, cfg_prdata));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic grow_automaton();
    logic [NODE_W-1:0] fresh;
    logic              linked;
    fresh  = pick_outsider();
    linked = 1'($urandom);
    load_attr(fresh, linked, linked ? ($urandom_range(0, 3) == 0 ? fresh : pick_member())
                                    : NODE_W'($urandom),
              DEPTH_W'($urandom), rand_count());
    for (int k = 0; k < 4; k++)
      load_edge(fresh, SYM_W'(k), ($urandom_range(0, 3) == 0) ? fresh : pick_member());
    is_member[fresh] = 1'b1;
    members.push_back(fresh);
    // make it reachable last, once its fan-out is closed
    load_edge(pick_member(), SYM_W'($urandom), fresh);
  endtask

  task automatic tweak_member();
    logic linked;
    if ($urandom_range(0, 1)) begin
      load_edge(pick_member(), SYM_W'($urandom), pick_member());
    end else begin
      linked = 1'($urandom);
      load_attr(pick_member(), linked, linked ? pick_member() : NODE_W'($urandom),
                DEPTH_W'($urandom), rand_count());
    end
  endtask

  task automatic send_noise();
    dna_item_t it;
    it = rand_fields();
    case ($urandom_range(0, 2))
      0: it.op = OP_SPARE;
      1: begin
        it.op   = OP_TRANS;
        it.node = pick_outsider();
      end
      default: begin
        it.op   = OP_ATTR;
        it.node = pick_outsider();
      end
    endcase
    send_item(it);
  endtask

  task automatic random_read();
    int unsigned len;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
    for (int b = 0; b < len; b++) begin
      if (b != 0 && $urandom_range(0, 24) == 0) begin
        if ($urandom_range(0, 1)) tweak_member();
        else send_noise();
      end
      send_base(SYM_W'($urandom), b == len - 1);
    end
  endtask

  // root fans out A->1, C->2, G->4095, T->3 and every other node copies the root
  task automatic test_directed_matches();
    int unsigned dir_nodes[5];
    int unsigned fan[4];
    dir_nodes = '{0, 1, 2, 3, 4095};
    fan       = '{1, 2, 4095, 3};
    gap_pct   = 20;
    stall_pct = 20;
    load_attr(12'd0, 1'b0, 12'hABC, 6'd0, 32'd0);
    load_attr(12'd1, 1'b1, 12'd1, 6'd5, 32'd10);
    load_attr(12'd2, 1'b1, 12'd2, 6'd5, 32'd20);
    // link bit clear: target must be ignored; depth clips to the maximum
    load_attr(12'd3, 1'b0, 12'd4095, 6'd40, 32'd7);
    load_attr(12'd4095, 1'b1, 12'd4095, 6'd63, 32'hFFFF_FFFF);
    foreach (dir_nodes[i]) begin
      for (int s = 0; s < 4; s++)
        load_edge(NODE_W'(dir_nodes[i]), SYM_W'(s), NODE_W'(fan[s]));
      is_member[dir_nodes[i]] = 1'b1;
      members.push_back(dir_nodes[i]);
    end
    read_seq("T");
    read_seq("A");
    read_seq("AC");
    read_seq("CA");
    read_seq("AGA");
    read_seq("TTG");
    // unused opcode in the middle of a read
    send_base(SYM_A, 1'b0);
    send_noise();
    begin
      dna_item_t it;
      it    = rand_fields();
      it.op = OP_SPARE;
      send_item(it);
    end
    send_base(SYM_C, 1'b1);
  endtask

  task automatic test_bucket_counting();
    set_bucketing(1'b1);
    read_seq("G");
    read_seq("T");
    read_seq("T");
    repeat (11) read_seq("A");
    read_seq("CA");
    set_bucketing(1'b0);
    read_seq("CA");
  endtask

  task automatic test_mid_read_loads();
    send_base(SYM_A, 1'b0);
    load_attr(12'd2, 1'b1, 12'd2, 6'd6, 32'd20);
    send_base(SYM_C, 1'b1);
    // best keeps the count it saw; a later hit with a larger count wins
    send_base(SYM_A, 1'b0);
    load_attr(12'd1, 1'b1, 12'd1, 6'd5, 32'd500);
    send_base(SYM_A, 1'b1);
    send_base(SYM_T, 1'b0);
    load_edge(12'd3, SYM_A, 12'd2);
    send_base(SYM_A, 1'b1);
  endtask

  task automatic test_long_read();
    logic [SYM_W-1:0] sym;
    gap_pct   = 5;
    stall_pct = 10;
    // stay off G so the deepest hit lands past the position limit
    for (int i = 0; i < MAX_READ + 5; i++) begin
      sym = SYM_W'($urandom_range(0, 2));
      if (sym == SYM_G) sym = SYM_T;
      send_base(sym, 1'b0);
    end
    send_base(SYM_G, 1'b1);
  endtask

  task automatic test_random_traffic(int unsigned budget, int unsigned gap,
                                     int unsigned stall);
    int unsigned stop_at;
    int unsigned pick;
    gap_pct   = gap;
    stall_pct = stall;
    stop_at   = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (members.size() < 24 || (pick >= 70 && pick < 80 && members.size() < 400))
        grow_automaton();
      else if (pick < 70) random_read();
      else if (pick < 90) tweak_member();
      else send_noise();
    end
  endtask

  initial begin
    mismatches = 0;
    items_sent = 0;
    gap_pct    = 0;
    stall_pct  = 0;
    bucket_on  = 1'b0;
    clear_read();
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.operation       <= OP_BASE;
    in_ch.symbol          <= SYM_A;
    in_ch.last_symbol     <= 1'b0;
    in_ch.node            <= '0;
    in_ch.target_node     <= '0;
    in_ch.has_output_link <= 1'b0;
    in_ch.depth           <= '0;
    in_ch.match_count     <= '0;
    cfg_psel              <= 1'b0;
    cfg_penable           <= 1'b0;
    cfg_pwrite            <= 1'b0;
    cfg_paddr             <= '0;
    cfg_pwdata            <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_matches();
    test_bucket_counting();
    test_mid_read_loads();
    test_long_read();
    test_random_traffic(100, 15, 15);
    set_bucketing(1'b1);
    test_random_traffic(50, 30, 30);
    set_bucketing(1'b0);
    test_random_traffic(50, 8, 40);
    set_bucketing(1'b1);
    test_random_traffic(50, 0, 0);
    wait_drained();

    if (mismatches == 0 && bucket_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/dcmc_pkg.sv
rtl/dcmc_in_if.sv
rtl/dcmc_out_if.sv
rtl/dna_core_match_classifier.sv
tb/sv/tb_top.sv
